@@ design/assert_macros.svh @@
// Assertion macros used by the execute unit sources.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define RVX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset included.
`define RVX_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/rvx_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, field widths and opcodes of the register machine execute unit.
// No dependencies.
package rvx_pkg;

  localparam int CMD_W    = 4;
  localparam int OPA_W    = 16;
  localparam int DATA_W   = 32;
  localparam int OUT_PC_W = 16;

  localparam logic [CMD_W-1:0] CMD_MOVIMM   = 4'd0;
  localparam logic [CMD_W-1:0] CMD_MOVE     = 4'd1;
  localparam logic [CMD_W-1:0] CMD_LOADIND  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_STOREIND = 4'd3;
  localparam logic [CMD_W-1:0] CMD_ADD      = 4'd4;
  localparam logic [CMD_W-1:0] CMD_MUL      = 4'd5;
  localparam logic [CMD_W-1:0] CMD_SUB      = 4'd6;
  localparam logic [CMD_W-1:0] CMD_DIV      = 4'd7;
  localparam logic [CMD_W-1:0] CMD_BR       = 4'd8;
  localparam logic [CMD_W-1:0] CMD_LT       = 4'd9;
  localparam logic [CMD_W-1:0] CMD_GT       = 4'd10;
  localparam logic [CMD_W-1:0] CMD_EQ       = 4'd11;
  localparam logic [CMD_W-1:0] CMD_NE       = 4'd12;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic  en;
    data_t data;
  } rf_write_t;

  typedef struct packed {
    logic  start;
    data_t value;
  } idx_req_t;

  typedef struct packed {
    logic  start;
    data_t dividend;
    data_t divisor;
  } div_req_t;

endpackage

@@ design/rvx_regfile.sv @@
`timescale 1ns / 1ps
// Register file: one synchronous memory, one write and one registered read port.
// Per-entry valid bits make unwritten entries read as zero. Uses rvx_pkg.
module rvx_regfile import rvx_pkg::*; #(
  parameter int NUM_REGS = 32,
  localparam int IDX_BITS = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  rf_write_t           wr,
  input  logic [IDX_BITS-1:0] waddr,
  input  logic [IDX_BITS-1:0] raddr,
  output data_t               rdata
);

  data_t               mem [NUM_REGS];
  logic [NUM_REGS-1:0] valid;
  data_t               rd_q;
  logic                rd_valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[waddr] <= wr.data;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[waddr] <= 1'b1;
      end
      rd_valid <= valid[raddr];
    end
  end

  assign rdata = rd_valid ? rd_q : '0;

endmodule

@@ design/rvx_idxmod.sv @@
`timescale 1ns / 1ps
// Index reduction: a 32-bit value modulo NUM_REGS, eight bits per cycle,
// or a plain mask when NUM_REGS is a power of two. Uses rvx_pkg.
module rvx_idxmod import rvx_pkg::*; #(
  parameter int NUM_REGS = 32,
  localparam int IDX_BITS = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  idx_req_t            req,
  output logic                done,
  output logic [IDX_BITS-1:0] res
);

  localparam bit PW2      = (NUM_REGS & (NUM_REGS - 1)) == 0;
  localparam int REM_BITS = IDX_BITS + 1;
  localparam int CHUNK    = 8;
  localparam int NSTEP    = DATA_W / CHUNK;
  localparam int CNT_BITS = $clog2(NSTEP);
  localparam logic [REM_BITS-1:0] N_R = REM_BITS'(NUM_REGS);
  localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(NSTEP - 1);

  logic [DATA_W-1:0]   val;
  logic [REM_BITS-1:0] rem;
  logic [REM_BITS-1:0] rem_step;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;

  always_comb begin
    rem_step = rem;
    for (int i = 0; i < CHUNK; i++) begin
      rem_step = {rem_step[REM_BITS-2:0], val[DATA_W-1-i]};
      if (rem_step >= N_R) begin
        rem_step = rem_step - N_R;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        if (PW2) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy && cnt == LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      val <= req.value;
      rem <= '0;
      cnt <= '0;
      res <= req.value[IDX_BITS-1:0];
    end else if (busy) begin
      val <= {val[DATA_W-CHUNK-1:0], {CHUNK{1'b0}}};
      rem <= rem_step;
      cnt <= cnt + CNT_BITS'(1);
      if (cnt == LAST) begin
        res <= rem_step[IDX_BITS-1:0];
      end
    end
  end

endmodule

@@ design/rvx_divider.sv @@
`timescale 1ns / 1ps
// Signed 32-bit divider, quotient truncated toward zero, one bit per cycle.
// Restoring division on magnitudes, sign fixed in a final step. Uses rvx_pkg.
module rvx_divider import rvx_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output logic     done,
  output data_t    quot
);

  localparam int CNT_BITS = $clog2(DATA_W);
  localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(DATA_W - 1);

  logic [DATA_W-1:0]   q;
  logic [DATA_W:0]     rem;
  logic [DATA_W-1:0]   mb;
  logic                neg;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;
  logic                fix;
  logic [DATA_W-1:0]   a_u;
  logic [DATA_W-1:0]   b_u;
  logic [DATA_W:0]     rem_sh;
  logic                ge;

  assign a_u    = req.dividend;
  assign b_u    = req.divisor;
  assign rem_sh = {rem[DATA_W-1:0], q[DATA_W-1]};
  assign ge     = rem_sh >= {1'b0, mb};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == LAST) begin
        busy <= 1'b0;
        fix  <= 1'b1;
      end else if (fix) begin
        fix  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q   <= a_u[DATA_W-1] ? (DATA_W'(0) - a_u) : a_u;
      mb  <= b_u[DATA_W-1] ? (DATA_W'(0) - b_u) : b_u;
      neg <= a_u[DATA_W-1] ^ b_u[DATA_W-1];
      rem <= '0;
      cnt <= '0;
    end else if (busy) begin
      rem <= ge ? (rem_sh - {1'b0, mb}) : rem_sh;
      q   <= {q[DATA_W-2:0], ge};
      cnt <= cnt + CNT_BITS'(1);
    end
    if (fix) begin
      quot <= neg ? (DATA_W'(0) - q) : q;
    end
  end

endmodule

@@ design/register_vm_execute_unit.sv @@
`timescale 1ns / 1ps
// Register machine execute unit: one instruction per input transaction.
// Uses rvx_pkg, rvx_regfile, rvx_idxmod, rvx_divider and assert_macros.svh.
//
// Usage:
//   Input channel in_valid/in_ready carries cmd, operand_a, operand_b.
//   Output channel out_valid/out_ready carries next_pc, link_value,
//   written_value, wrote_register and divide_by_zero; one result per input.
//   One instruction is in flight at a time; the register file sits in a
//   synchronous memory with one read and one write port, read twice in turn.
//   A div waits for the one-bit-per-cycle divider unless its divisor is zero,
//   and a register count that is not a power of two makes each index
//   reduction iterate over the value instead of masking it.
//   in_ready rises in the cycle after each result is loaded into the output
//   register, so the next item is taken while that result still waits.
//   Reset clears the registers, the counter and the link register at once.
//   A stalled receiver holds the result; the unit then stops in write-back.
`include "assert_macros.svh"
module register_vm_execute_unit import rvx_pkg::*; #(
  parameter int NUM_REGS = 32,
  parameter int PC_BITS  = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [OPA_W-1:0]    operand_a,
  input  data_t               operand_b,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OUT_PC_W-1:0] next_pc,
  output logic [OUT_PC_W-1:0] link_value,
  output data_t               written_value,
  output logic                wrote_register,
  output logic                divide_by_zero
);

  localparam int IDX_BITS = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_IDX  = 4'd1;
  localparam logic [3:0] S_RA   = 4'd2;
  localparam logic [3:0] S_RB   = 4'd3;
  localparam logic [3:0] S_RD   = 4'd4;
  localparam logic [3:0] S_IDX2 = 4'd5;
  localparam logic [3:0] S_EXEC = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_WB   = 4'd8;

  logic [3:0]          state;
  logic [3:0]          state_next;
  logic [CMD_W-1:0]    cmd_q;
  logic [OPA_W-1:0]    opa_q;
  data_t               opb_q;
  logic [IDX_BITS-1:0] d_q;
  logic [IDX_BITS-1:0] s_q;
  logic [IDX_BITS-1:0] x_q;
  logic [IDX_BITS-1:0] widx_q;
  data_t               va;
  data_t               vb;
  data_t               wval_q;
  logic                wr_q;
  logic                dz_q;
  logic                br_q;
  logic [PC_BITS-1:0]  pc;
  logic [PC_BITS-1:0]  link;
  logic [PC_BITS-1:0]  pc_next;
  logic [PC_BITS-1:0]  link_next;

  logic                accept;
  logic                wb_fire;
  logic                is_branch;
  logic                needs_d;
  logic [IDX_BITS-1:0] raddr;
  data_t               rf_rdata;
  rf_write_t           rf_wr;
  idx_req_t            moda_req;
  idx_req_t            modb_req;
  logic                moda_done;
  logic                modb_done;
  logic [IDX_BITS-1:0] moda_res;
  logic [IDX_BITS-1:0] modb_res;
  div_req_t            div_req;
  logic                div_done;
  data_t               div_quot;

  assign in_ready  = state == S_IDLE;
  assign accept    = in_valid && in_ready;
  assign wb_fire   = (state == S_WB) && (!out_valid || out_ready);
  assign is_branch = (cmd_q >= CMD_BR) && (cmd_q <= CMD_NE);
  assign needs_d   = (cmd_q == CMD_STOREIND) || (cmd_q == CMD_ADD) || (cmd_q == CMD_MUL) ||
                     (cmd_q == CMD_SUB) || (cmd_q == CMD_DIV);

  rvx_regfile #(.NUM_REGS(NUM_REGS)) u_regfile (
    .clk   (clk),
    .rst   (rst),
    .wr    (rf_wr),
    .waddr (widx_q),
    .raddr (raddr),
    .rdata (rf_rdata)
  );

  rvx_idxmod #(.NUM_REGS(NUM_REGS)) u_idxmod_a (
    .clk  (clk),
    .rst  (rst),
    .req  (moda_req),
    .done (moda_done),
    .res  (moda_res)
  );

  rvx_idxmod #(.NUM_REGS(NUM_REGS)) u_idxmod_b (
    .clk  (clk),
    .rst  (rst),
    .req  (modb_req),
    .done (modb_done),
    .res  (modb_res)
  );

  rvx_divider u_divider (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  always_comb begin
    moda_req.start = accept || (state == S_RB && cmd_q == CMD_LOADIND) ||
                     (state == S_RD && cmd_q == CMD_STOREIND);
    moda_req.value = (state == S_IDLE) ? data_t'({{(DATA_W-OPA_W){1'b0}}, operand_a})
                                       : rf_rdata;
    modb_req.start = accept;
    modb_req.value = operand_b;
    div_req.start    = (state == S_EXEC) && (cmd_q == CMD_DIV) && (va != '0);
    div_req.dividend = vb;
    div_req.divisor  = va;
    rf_wr.en   = wb_fire && wr_q;
    rf_wr.data = wval_q;
  end

  always_comb begin
    case (state)
      S_RA:    raddr = is_branch ? '0 : s_q;
      S_IDX2:  raddr = moda_res;
      default: raddr = d_q;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = S_IDX;
      S_IDX:  if (moda_done && modb_done) state_next = S_RA;
      S_RA:   state_next = S_RB;
      S_RB: begin
        if (cmd_q == CMD_LOADIND) state_next = S_IDX2;
        else if (needs_d) state_next = S_RD;
        else state_next = S_EXEC;
      end
      S_RD:   state_next = (cmd_q == CMD_STOREIND) ? S_IDX2 : S_EXEC;
      S_IDX2: begin
        if (moda_done) state_next = (cmd_q == CMD_LOADIND) ? S_RD : S_EXEC;
      end
      S_EXEC: state_next = div_req.start ? S_DIV : S_WB;
      S_DIV:  if (div_done) state_next = S_WB;
      S_WB:   if (wb_fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (br_q) begin
      pc_next   = PC_BITS'(opa_q);
      link_next = pc;
    end else begin
      pc_next   = pc + PC_BITS'(1);
      link_next = link;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      link      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (wb_fire) begin
        pc        <= pc_next;
        link      <= link_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
      opa_q <= operand_a;
      opb_q <= operand_b;
    end
    if (state == S_IDX && moda_done) begin
      d_q <= moda_res;
      s_q <= modb_res;
    end
    if (state == S_RB) begin
      va <= rf_rdata;
    end
    if (state == S_RD) begin
      vb <= rf_rdata;
    end
    if (state == S_IDX2 && moda_done) begin
      x_q <= moda_res;
    end
    if (state == S_EXEC) begin
      wr_q   <= 1'b0;
      dz_q   <= 1'b0;
      br_q   <= 1'b0;
      widx_q <= d_q;
      wval_q <= opb_q;
      case (cmd_q)
        CMD_MOVIMM:   wr_q <= 1'b1;
        CMD_MOVE: begin
          wr_q   <= 1'b1;
          wval_q <= va;
        end
        CMD_LOADIND: begin
          wr_q   <= 1'b1;
          wval_q <= vb;
        end
        CMD_STOREIND: begin
          wr_q   <= 1'b1;
          widx_q <= x_q;
          wval_q <= va;
        end
        CMD_ADD: begin
          wr_q   <= 1'b1;
          wval_q <= vb + va;
        end
        CMD_MUL: begin
          wr_q   <= 1'b1;
          wval_q <= vb * va;
        end
        CMD_SUB: begin
          wr_q   <= 1'b1;
          wval_q <= vb - va;
        end
        CMD_DIV: begin
          if (va == '0) dz_q <= 1'b1;
          else wr_q <= 1'b1;
        end
        CMD_BR:  br_q <= 1'b1;
        CMD_LT:  br_q <= va < opb_q;
        CMD_GT:  br_q <= va > opb_q;
        CMD_EQ:  br_q <= va == opb_q;
        CMD_NE:  br_q <= va != opb_q;
        default: br_q <= 1'b0;
      endcase
    end
    if (state == S_DIV && div_done) begin
      wval_q <= div_quot;
    end
    if (wb_fire) begin
      next_pc        <= OUT_PC_W'(pc_next);
      link_value     <= OUT_PC_W'(link_next);
      written_value  <= wr_q ? wval_q : '0;
      wrote_register <= wr_q;
      divide_by_zero <= dz_q;
    end
  end

  `RVX_ASSERT(a_write_in_wb, rf_wr.en |-> state == S_WB, "register write outside write-back")
  `RVX_ASSERT(a_div_done_in_div, div_done |-> state == S_DIV, "divider finished outside wait")
  `RVX_ASSERT(a_dz_no_write, out_valid |-> !(divide_by_zero && wrote_register), "dz with write")
  `RVX_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid && state == S_IDLE, "not idle after reset")

endmodule
